// File: rtl/core/ptdt_pkg.sv
package ptdt_pkg;

   localparam int TABLE_DEPTH_DEF = 16;

   localparam logic [1:0] OP_TICK   = 2'd0;
   localparam logic [1:0] OP_ADD    = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;

   localparam logic [1:0] ST_NONE     = 2'd0;
   localparam logic [1:0] ST_FIRED    = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;
   localparam logic [1:0] ST_NOTFOUND = 2'd3;

   localparam logic [31:0] CD_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] CD_MIN = 32'h8000_0000;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [7:0]  task_id;
      logic [30:0] period_ms;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      logic [7:0] fired_task;
      logic [1:0] status;
      logic       last;
   } rsp_type;

   // one table entry; countdown is two's complement
   typedef struct packed {
      logic [7:0]  task_id;
      logic [30:0] period;
      logic [31:0] countdown;
   } entry_type;

endpackage

// File: rtl/core/ptdt_mem.sv
module ptdt_mem #(
   parameter int DEPTH = ptdt_pkg::TABLE_DEPTH_DEF,
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [IDX_W-1:0]     wr_addr,
   input  ptdt_pkg::entry_type  wr_data,
   input  logic                 rd_en,
   input  logic [IDX_W-1:0]     rd_addr,
   output ptdt_pkg::entry_type  rd_data
);

   ptdt_pkg::entry_type mem [DEPTH];
   ptdt_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      // read data holds while no read is issued
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/ptdt_ctrl.sv
module ptdt_ctrl #(
   parameter int DEPTH = ptdt_pkg::TABLE_DEPTH_DEF,
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  ptdt_pkg::req_type    req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output ptdt_pkg::rsp_type    rsp_data,
   output logic                 mem_wr_en,
   output logic [IDX_W-1:0]     mem_wr_addr,
   output ptdt_pkg::entry_type  mem_wr_data,
   output logic                 mem_rd_en,
   output logic [IDX_W-1:0]     mem_rd_addr,
   input  ptdt_pkg::entry_type  mem_rd_data
);

   typedef enum logic [1:0] {IDLE, WALK, FINISH} state_type;

   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

   state_type         state_ff, state_in;
   logic [1:0]        op_ff, op_in;
   logic [7:0]        id_ff, id_in;
   logic [31:0]       elapsed_ff, elapsed_in;
   logic [31:0]       last_tick_ff, last_tick_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0]  proc_idx_ff, proc_idx_in;
   logic              data_vld_ff, data_vld_in;
   logic [CNT_W-1:0]  keep_ff, keep_in;
   logic              held_vld_ff, held_vld_in;
   logic [7:0]        held_id_ff, held_id_in;
   logic [1:0]        fin_status_ff, fin_status_in;
   logic              rsp_valid_ff, rsp_valid_in;
   ptdt_pkg::rsp_type rsp_ff, rsp_in;

   logic              accept;
   logic              out_free;
   logic [32:0]       diff;
   logic [31:0]       cd_next;
   logic              fire;
   logic              fire_now;
   logic              stall_walk;
   logic              keep_hit;
   logic [CNT_W-1:0]  keep_nx;

   assign req_stall = (state_ff != IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // countdown minus elapsed, both sign-extended to 33 bits
   assign diff = {mem_rd_data.countdown[31], mem_rd_data.countdown}
               - {elapsed_ff[31], elapsed_ff};
   assign cd_next = (diff[32] != diff[31]) ? (diff[32] ? ptdt_pkg::CD_MIN : ptdt_pkg::CD_MAX)
                                           : diff[31:0];
   assign fire     = diff[32] || (diff == '0);
   assign fire_now = data_vld_ff && (op_ff == ptdt_pkg::OP_TICK) && fire;
   // a fired id is held back one slot so the final one can carry last
   assign stall_walk = fire_now && held_vld_ff && !out_free;
   assign keep_hit   = data_vld_ff && (op_ff == ptdt_pkg::OP_REMOVE)
                    && (mem_rd_data.task_id != id_ff);
   assign keep_nx    = keep_hit ? keep_ff + 1'b1 : keep_ff;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      id_in         = id_ff;
      elapsed_in    = elapsed_ff;
      last_tick_in  = last_tick_ff;
      count_in      = count_ff;
      rd_idx_in     = rd_idx_ff;
      proc_idx_in   = proc_idx_ff;
      data_vld_in   = data_vld_ff;
      keep_in       = keep_ff;
      held_vld_in   = held_vld_ff;
      held_id_in    = held_id_ff;
      fin_status_in = fin_status_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_in        = rsp_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = proc_idx_ff;
      mem_wr_data   = mem_rd_data;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = rd_idx_ff[IDX_W-1:0];

      unique case (state_ff)
         IDLE: begin
            if (accept) begin
               op_in         = req_data.opcode;
               id_in         = req_data.task_id;
               rd_idx_in     = '0;
               data_vld_in   = 1'b0;
               keep_in       = '0;
               held_vld_in   = 1'b0;
               fin_status_in = ptdt_pkg::ST_NONE;
               state_in      = FINISH;
               priority case (req_data.opcode)
                  ptdt_pkg::OP_ADD: begin
                     if (count_ff >= DEPTH_C) begin
                        fin_status_in = ptdt_pkg::ST_FULL;
                     end else begin
                        mem_wr_en                 = 1'b1;
                        mem_wr_addr               = count_ff[IDX_W-1:0];
                        mem_wr_data.task_id       = req_data.task_id;
                        mem_wr_data.period        = req_data.period_ms;
                        mem_wr_data.countdown     = {1'b0, req_data.period_ms};
                        count_in                  = count_ff + 1'b1;
                     end
                  end
                  ptdt_pkg::OP_REMOVE: begin
                     state_in = WALK;
                  end
                  ptdt_pkg::OP_TICK: begin
                     if (req_data.now_ms != last_tick_ff) begin
                        elapsed_in   = req_data.now_ms - last_tick_ff;
                        last_tick_in = req_data.now_ms;
                        state_in     = WALK;
                     end
                  end
                  default: begin
                     state_in = FINISH;
                  end
               endcase
            end
         end
         WALK: begin
            if (!stall_walk) begin
               if (data_vld_ff) begin
                  if (op_ff == ptdt_pkg::OP_TICK) begin
                     mem_wr_en   = 1'b1;
                     mem_wr_addr = proc_idx_ff;
                     mem_wr_data.countdown = fire ? {1'b0, mem_rd_data.period} : cd_next;
                     if (fire) begin
                        if (held_vld_ff) begin
                           rsp_valid_in = 1'b1;
                           rsp_in       = '{fired_task: held_id_ff,
                                            status: ptdt_pkg::ST_FIRED, last: 1'b0};
                        end
                        held_vld_in = 1'b1;
                        held_id_in  = mem_rd_data.task_id;
                     end
                  end else if (keep_hit) begin
                     // compaction: keep index never passes the read index
                     mem_wr_en   = 1'b1;
                     mem_wr_addr = keep_ff[IDX_W-1:0];
                  end
               end
               keep_in = keep_nx;
               if (rd_idx_ff < count_ff) begin
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = rd_idx_ff[IDX_W-1:0];
                  proc_idx_in = rd_idx_ff[IDX_W-1:0];
                  rd_idx_in   = rd_idx_ff + 1'b1;
                  data_vld_in = 1'b1;
               end else begin
                  data_vld_in = 1'b0;
                  state_in    = FINISH;
                  if (op_ff == ptdt_pkg::OP_REMOVE) begin
                     count_in      = keep_nx;
                     fin_status_in = (keep_nx == count_ff) ? ptdt_pkg::ST_NOTFOUND
                                                           : ptdt_pkg::ST_NONE;
                  end
               end
            end
         end
         FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = held_vld_ff
                  ? '{fired_task: held_id_ff, status: ptdt_pkg::ST_FIRED, last: 1'b1}
                  : '{fired_task: 8'd0, status: fin_status_ff, last: 1'b1};
               held_vld_in  = 1'b0;
               state_in     = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         count_ff     <= '0;
         last_tick_ff <= '0;
         data_vld_ff  <= 1'b0;
         held_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         last_tick_ff <= last_tick_in;
         data_vld_ff  <= data_vld_in;
         held_vld_ff  <= held_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      id_ff         <= id_in;
      elapsed_ff    <= elapsed_in;
      rd_idx_ff     <= rd_idx_in;
      proc_idx_ff   <= proc_idx_in;
      keep_ff       <= keep_in;
      held_id_ff    <= held_id_in;
      fin_status_ff <= fin_status_in;
      rsp_ff        <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("entry count above table depth");

   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      (mem_rd_en && mem_wr_en) |-> (mem_rd_addr != mem_wr_addr))
      else $error("read and write hit the same entry");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      accept |=> req_stall)
      else $error("new word taken while an item is in progress");

   a_held_tick_only: assert property (@(posedge clock) disable iff (reset)
      held_vld_ff |-> (op_ff == ptdt_pkg::OP_TICK && state_ff != IDLE))
      else $error("held fired id outside a tick");

   a_compact_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == WALK && op_ff == ptdt_pkg::OP_REMOVE) |-> (keep_ff <= rd_idx_ff))
      else $error("compaction index passed read index");

endmodule

// File: rtl/core/periodic_task_dispatch_table_top.sv
// Add, unused opcode and unchanged-time tick go straight to the finish state for their one result.
// Remove and tick walk the table one entry per cycle, a tick only while no fired id is stalled;
// the final result follows the walk. One item at a time: a new request is taken only in idle,
// and the walk waits while the result side stalls, since each fired id needs the output register.
// Reset clears entry count, last tick time and all handshake state; the table memory
// itself is not cleared (only entries below the count are ever read).
module periodic_task_dispatch_table_top #(
   parameter int TABLE_DEPTH = ptdt_pkg::TABLE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ptdt_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ptdt_pkg::rsp_type rsp_data
);

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   logic                mem_wr_en;
   logic [IDX_W-1:0]    mem_wr_addr;
   ptdt_pkg::entry_type mem_wr_data;
   logic                mem_rd_en;
   logic [IDX_W-1:0]    mem_rd_addr;
   ptdt_pkg::entry_type mem_rd_data;

   ptdt_ctrl #(.DEPTH(TABLE_DEPTH)) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   ptdt_mem #(.DEPTH(TABLE_DEPTH)) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule
